### sv/lgen_pkg.sv
package lgen_pkg;

	localparam int KIND_W    = 2;
	localparam int LAYER_W   = 3;
	localparam int ROW_W     = 3;
	localparam int BITS_W    = 5;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 16;
	localparam int FIELDS_W  = LAYER_W + ROW_W + BITS_W;
	localparam int PAD_W     = M_TDATA_W - FIELDS_W;

	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_SEED = 2'd0;
	localparam kind_t KIND_STEP = 2'd1;
	localparam kind_t KIND_READ = 2'd2;

endpackage

### sv/lgen_store.sv
module lgen_store #(
	parameter int DEPTH = 25,
	parameter int WIDTH = 5,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data_s1,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] raw_s1;
	logic             hit_s1;

	// entries never written since reset read as dead cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_s1  <= 1'b0;
		end else begin
			if (wr_en)
				valid_q[wr_addr] <= 1'b1;
			if (rd_en)
				hit_s1 <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			raw_s1 <= mem[rd_addr];
	end

	assign rd_data_s1 = hit_s1 ? raw_s1 : '0;

endmodule

### sv/lgen_rule.sv
module lgen_rule #(
	parameter int GRID = 5
) (
	input  logic [GRID-1:0] up,
	input  logic [GRID-1:0] cur,
	input  logic [GRID-1:0] dn,
	output logic [GRID-1:0] nxt
);

	for (genvar c = 0; c < GRID; c++) begin : g_col
		localparam int LF = (c + GRID - 1) % GRID;
		localparam int RT = (c + 1) % GRID;
		logic [3:0] n;

		assign n = 4'(up[LF]) + 4'(up[c]) + 4'(up[RT])
			+ 4'(cur[LF]) + 4'(cur[RT])
			+ 4'(dn[LF]) + 4'(dn[c]) + 4'(dn[RT]);

		// survive on two or three, birth on three
		assign nxt[c] = (n == 4'd3) || (cur[c] && n == 4'd2);
	end

endmodule

### sv/layered_life_generation_unit.sv
// Layered life generator. A stack of LAYERS layers of GRID x GRID cells lives in
// one single-port-read synchronous memory, one row word per entry, with a
// per-entry valid bit so that reset takes effect at once (no clearing pass).
// Layers are addressed through a rotating base slot, so the upward shift of a
// step moves no data. Requests on s_axis: tuser is the kind (seed row, step,
// read row); a seed write does not hold the input, a read holds it until its
// result, through the memory read register, is loaded into the output register.
// A step walks the rows of the bottom layer through the memory read port,
// GRID + 2 row reads in all, and computes one new row per cycle, unless the
// output stalls, from a three-row window. Each new row passes the memory read
// register, the window and the output register; the input is held until the
// last row is loaded, and a stalled output holds the walk. One request is worked at a time.
module layered_life_generation_unit
	import lgen_pkg::*;
#(
	parameter int GRID   = 5,
	parameter int LAYERS = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// layer[2:0], row[5:3], row_bits[10:6], zero [15:11]
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// kind[1:0]
	input  logic [KIND_W-1:0]    s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// out_layer[2:0], out_row[5:3], out_bits[10:6], zero [15:11]
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	output logic                 m_axis_tlast
);

	localparam int SW  = $clog2(LAYERS);
	localparam int RW  = $clog2(GRID);
	localparam int AW  = $clog2(LAYERS * GRID);
	localparam int NRD = GRID + 2;
	localparam int IW  = $clog2(NRD + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_GEN
	} state_t;

	state_t state_q;

	kind_t               in_kind;
	logic [LAYER_W-1:0]  in_layer;
	logic [ROW_W-1:0]    in_row;
	logic [BITS_W-1:0]   in_bits;
	logic                in_range;
	logic                accept;

	logic [SW+LAYER_W-1:0] lay_ext;
	logic [RW+ROW_W-1:0]   row_ext;
	logic [GRID+BITS_W-1:0] seed_ext;
	logic [SW-1:0]         lay_sw;
	logic [RW-1:0]         row_rw;
	logic [GRID-1:0]       seed_row;
	logic [SW:0]           slot_sum;
	logic [SW:0]           slot_wrap;
	logic [SW-1:0]         slot;
	logic [AW-1:0]         req_addr;

	logic [SW-1:0]   base_q;
	logic [SW-1:0]   dst_slot;
	logic [IW-1:0]   iss_q;
	logic [RW-1:0]   erow_q;
	logic [1:0]      ccnt_q;
	logic            cap_pend_q;
	logic            row_pend_q;
	logic [RW-1:0]   rrow;
	logic [AW-1:0]   gen_rd_addr;
	logic [AW-1:0]   gen_wr_addr;
	logic            out_free;
	logic            out_load;
	logic            emit_now;
	logic            can_cap;
	logic            issue;
	logic            gen_done;

	logic [GRID-1:0] w_up_q;
	logic [GRID-1:0] w_cur_q;
	logic [GRID-1:0] w_dn_q;
	logic [GRID-1:0] nxt_row;

	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic [GRID-1:0] rd_data_s1;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [GRID-1:0] wr_data;

	logic [LAYER_W-1:0] rd_layer_q;
	logic [ROW_W-1:0]   rd_row_q;
	logic               rd_inr_q;

	logic [GRID+BITS_W-1:0] nxt_ext;
	logic [GRID+BITS_W-1:0] rdd_ext;
	logic [RW+ROW_W-1:0]    erow_ext;

	logic               out_valid_q;
	logic [LAYER_W-1:0] out_layer_q;
	logic [ROW_W-1:0]   out_row_q;
	logic [BITS_W-1:0]  out_bits_q;
	logic               out_last_q;

	assign in_kind  = s_axis_tuser;
	assign in_layer = s_axis_tdata[LAYER_W-1:0];
	assign in_row   = s_axis_tdata[LAYER_W+ROW_W-1:LAYER_W];
	assign in_bits  = s_axis_tdata[FIELDS_W-1:LAYER_W+ROW_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_range      = (int'(in_layer) < LAYERS) && (int'(in_row) < GRID);

	assign lay_ext  = {{SW{1'b0}}, in_layer};
	assign row_ext  = {{RW{1'b0}}, in_row};
	assign seed_ext = {{GRID{1'b0}}, in_bits};
	assign lay_sw   = lay_ext[SW-1:0];
	assign row_rw   = row_ext[RW-1:0];
	assign seed_row = seed_ext[GRID-1:0];

	// logical layer to physical slot, rotated by the base
	assign slot_sum  = {1'b0, base_q} + {1'b0, lay_sw};
	assign slot_wrap = slot_sum - (SW+1)'(LAYERS);
	assign slot      = (slot_sum >= (SW+1)'(LAYERS)) ? slot_wrap[SW-1:0] : slot_sum[SW-1:0];
	assign req_addr  = AW'(slot) * AW'(GRID) + AW'(row_rw);

	// the old top slot becomes the new bottom layer
	assign dst_slot = (base_q == '0) ? SW'(LAYERS - 1) : base_q - SW'(1);

	// read order: last row, rows 0 to GRID-1, then row 0 again
	always_comb begin
		if (iss_q == '0)
			rrow = RW'(GRID - 1);
		else if (iss_q == IW'(NRD - 1))
			rrow = '0;
		else
			rrow = RW'(iss_q - IW'(1));
	end

	assign gen_rd_addr = AW'(base_q) * AW'(GRID) + AW'(rrow);
	assign gen_wr_addr = AW'(dst_slot) * AW'(GRID) + AW'(erow_q);

	assign out_free = !out_valid_q || m_axis_tready;
	assign emit_now = (state_q == ST_GEN) && row_pend_q && out_free;
	assign out_load = ((state_q == ST_READ) && out_free) || emit_now;
	assign can_cap  = (state_q == ST_GEN) && cap_pend_q && (!row_pend_q || emit_now);
	assign issue    = (state_q == ST_GEN) && (iss_q != IW'(NRD)) && (!cap_pend_q || can_cap);
	assign gen_done = emit_now && (erow_q == RW'(GRID - 1));

	lgen_rule #(.GRID(GRID)) u_rule (
		.up  (w_up_q),
		.cur (w_cur_q),
		.dn  (w_dn_q),
		.nxt (nxt_row)
	);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = req_addr;
		wr_en   = 1'b0;
		wr_addr = req_addr;
		wr_data = seed_row;
		if (state_q == ST_GEN) begin
			rd_en   = issue;
			rd_addr = gen_rd_addr;
			wr_en   = emit_now;
			wr_addr = gen_wr_addr;
			wr_data = nxt_row;
		end else if (accept && in_range) begin
			rd_en = (in_kind == KIND_READ);
			wr_en = (in_kind == KIND_SEED);
		end
	end

	lgen_store #(.DEPTH(LAYERS * GRID), .WIDTH(GRID)) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data_s1 (rd_data_s1),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	assign nxt_ext  = {{BITS_W{1'b0}}, nxt_row};
	assign rdd_ext  = {{BITS_W{1'b0}}, rd_data_s1};
	assign erow_ext = {{ROW_W{1'b0}}, erow_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			iss_q       <= '0;
			erow_q      <= '0;
			ccnt_q      <= '0;
			cap_pend_q  <= 1'b0;
			row_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !m_axis_tready);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_kind)
							KIND_STEP: begin
								state_q    <= ST_GEN;
								iss_q      <= '0;
								erow_q     <= '0;
								ccnt_q     <= '0;
								cap_pend_q <= 1'b0;
								row_pend_q <= 1'b0;
							end
							KIND_READ: state_q <= ST_READ;
							default: ;
						endcase
					end
				end
				ST_READ: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				ST_GEN: begin
					if (issue)
						iss_q <= iss_q + IW'(1);
					cap_pend_q <= issue || (cap_pend_q && !can_cap);
					row_pend_q <= (row_pend_q && !emit_now) || (can_cap && ccnt_q == 2'd2);
					if (can_cap && ccnt_q != 2'd2)
						ccnt_q <= ccnt_q + 2'd1;
					if (emit_now)
						erow_q <= erow_q + RW'(1);
					if (gen_done) begin
						base_q  <= dst_slot;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_kind == KIND_READ) begin
			rd_layer_q <= in_layer;
			rd_row_q   <= in_row;
			rd_inr_q   <= in_range;
		end
		if (can_cap) begin
			w_up_q  <= w_cur_q;
			w_cur_q <= w_dn_q;
			w_dn_q  <= rd_data_s1;
		end
		if (state_q == ST_READ && out_free) begin
			out_layer_q <= rd_layer_q;
			out_row_q   <= rd_row_q;
			out_bits_q  <= rd_inr_q ? rdd_ext[BITS_W-1:0] : '0;
			out_last_q  <= 1'b1;
		end else if (emit_now) begin
			out_layer_q <= '0;
			out_row_q   <= erow_ext[ROW_W-1:0];
			out_bits_q  <= nxt_ext[BITS_W-1:0];
			out_last_q  <= (erow_q == RW'(GRID - 1));
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_bits_q, out_row_q, out_layer_q};
	assign m_axis_tlast  = out_last_q;

endmodule

### sv/lgen_checker.sv
module lgen_checker
	import lgen_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic [S_TDATA_W-1:0] s_axis_tdata,
	input logic [KIND_W-1:0]    s_axis_tuser,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata,
	input logic                 m_axis_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// a request that yields results blocks the next one
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready &&
			(s_axis_tuser == KIND_STEP || s_axis_tuser == KIND_READ) |=> !s_axis_tready)
		else $error("request taken while a result-producing request is open");

	// seed writes finish at once
	a_seed: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_SEED |=> s_axis_tready)
		else $error("seed write held the input");

	// a finished read result is one item with last set
	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_READ |=> ##1
			m_axis_tvalid && m_axis_tlast)
		else $error("read result missing or not marked last");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:FIELDS_W] == '0)
		else $error("padding bits of result not zero");

endmodule

bind layered_life_generation_unit lgen_checker u_lgen_checker (.*);
